/* rtl/stc_pkg.sv */
`timescale 1ns / 1ps
// stc_pkg: constants, types and the month table shared by the seconds to
// calendar date pipeline. No dependencies.
package stc_pkg;

  localparam int NSTAGE = 11;
  localparam int LAST   = NSTAGE - 1;

  // Stage indexes
  localparam int ST_TOTAL = 0;
  localparam int ST_Q675  = 1;
  localparam int ST_SPLIT = 2;
  localparam int ST_Q400  = 3;
  localparam int ST_R400  = 4;
  localparam int ST_CENT  = 5;
  localparam int ST_Q4    = 6;
  localparam int ST_R4    = 7;
  localparam int ST_YEAR  = 8;
  localparam int ST_MONTH = 9;
  localparam int ST_DAY   = 10;
  localparam int ST_QSEC  = 3;
  localparam int ST_RSEC  = 4;
  localparam int ST_QMIN  = 5;
  localparam int ST_RMIN  = 6;

  localparam logic [39:0] UNIX_OFFSET = 40'd62167219200;
  localparam logic [39:0] LIMIT_SECS  = 40'd315569520000;

  // 86400 = 128 * 675
  localparam int DAY_LO_W = 7;
  localparam int D675     = 675;
  localparam int D675_SH  = 32;
  localparam logic [22:0] D675_MUL = 23'((64'd1 << D675_SH) / D675);

  localparam int DAYS_400Y       = 146097;
  localparam int D400_SH         = 40;
  localparam logic [22:0] D400_MUL = 23'((64'd1 << D400_SH) / DAYS_400Y);

  localparam int DAYS_100Y_FIRST = 36525;
  localparam int DAYS_100Y       = 36524;
  localparam int DAYS_4Y         = 1461;
  localparam int DAYS_4Y_SHORT   = 1460;
  localparam int D1461_SH        = 28;
  localparam logic [17:0] D1461_MUL = 18'((64'd1 << D1461_SH) / DAYS_4Y);

  localparam int DAYS_LEAP_YEAR  = 366;
  localparam int DAYS_YEAR       = 365;

  localparam int D60     = 60;
  localparam int D60_SH  = 24;
  localparam logic [18:0] D60_MUL = 19'((64'd1 << D60_SH) / D60);

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Day of year on which month idx (0 = January) starts
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && idx >= 4'd2) ? 9'd1 : 9'd0);
  endfunction

endpackage

/* rtl/stc_tod.sv */
`timescale 1ns / 1ps
// stc_tod: splits seconds of day into hour, minute and second over four
// stages, then carries the result to the last stage. Uses stc_pkg.
module stc_tod (
  input  logic               clk,
  input  stc_pkg::stage_en_t en,
  input  logic [16:0]        sod,
  output stc_pkg::tod_t      tod
);

  localparam int HOLD = stc_pkg::LAST - stc_pkg::ST_RMIN;

  logic [35:0] p3;
  logic [10:0] q3_r;
  logic [16:0] sod3_r;

  logic [16:0] m4;
  logic [6:0]  r4;
  logic        ge4;
  logic [10:0] mins4_r;
  logic [5:0]  sec4_r;

  logic [29:0] p5;
  logic [4:0]  q5_r;
  logic [10:0] mins5_r;
  logic [5:0]  sec5_r;

  logic [10:0] m6;
  logic [6:0]  r6;
  logic        ge6;
  stc_pkg::tod_t tod6_r;
  stc_pkg::tod_t hold_r [HOLD];

  assign p3  = 36'(sod) * 36'(stc_pkg::D60_MUL);
  assign m4  = 17'(q3_r) * 17'(stc_pkg::D60);
  assign r4  = sod3_r[6:0] - m4[6:0];
  assign ge4 = r4 >= 7'(stc_pkg::D60);
  assign p5  = 30'(mins4_r) * 30'(stc_pkg::D60_MUL);
  assign m6  = 11'(q5_r) * 11'(stc_pkg::D60);
  assign r6  = mins5_r[6:0] - m6[6:0];
  assign ge6 = r6 >= 7'(stc_pkg::D60);

  always_ff @(posedge clk) begin
    if (en[stc_pkg::ST_QSEC]) begin
      q3_r   <= p3[stc_pkg::D60_SH +: 11];
      sod3_r <= sod;
    end
    if (en[stc_pkg::ST_RSEC]) begin
      mins4_r <= ge4 ? q3_r + 11'd1 : q3_r;
      sec4_r  <= 6'(ge4 ? r4 - 7'(stc_pkg::D60) : r4);
    end
    if (en[stc_pkg::ST_QMIN]) begin
      q5_r    <= p5[stc_pkg::D60_SH +: 5];
      mins5_r <= mins4_r;
      sec5_r  <= sec4_r;
    end
    if (en[stc_pkg::ST_RMIN]) begin
      tod6_r.hour   <= ge6 ? q5_r + 5'd1 : q5_r;
      tod6_r.minute <= 6'(ge6 ? r6 - 7'(stc_pkg::D60) : r6);
      tod6_r.second <= sec5_r;
    end
    if (en[stc_pkg::ST_RMIN + 1]) begin
      hold_r[0] <= tod6_r;
    end
    for (int i = 1; i < HOLD; i++) begin
      if (en[stc_pkg::ST_RMIN + 1 + i]) begin
        hold_r[i] <= hold_r[i-1];
      end
    end
  end

  assign tod = hold_r[HOLD-1];

endmodule

/* rtl/stc_date.sv */
`timescale 1ns / 1ps
// stc_date: breaks a day count from year 0 into year, month and day over
// eight stages (400-, 100-, 4- and 1-year cycles, then months). Uses stc_pkg.
module stc_date (
  input  logic               clk,
  input  stc_pkg::stage_en_t en,
  input  logic [21:0]        days,
  output stc_pkg::date_t     date
);

  // 400-year cycles
  logic [44:0] p3;
  logic [4:0]  n0_3_r;
  logic [21:0] days3_r;

  logic [21:0] m4;
  logic [18:0] r4;
  logic        ge4;
  logic [4:0]  n400_4_r;
  logic [17:0] d1_4_r;

  // centuries
  logic        c1, c2, c3;
  logic [17:0] coff;
  logic [1:0]  cnum;
  logic [15:0] d2_5_r;
  logic [13:0] base5_r;
  logic        leapc5_r;

  // 4-year cycles
  logic [15:0] e6;
  logic [33:0] p6;
  logic [15:0] e6_r;
  logic [4:0]  q6_r;
  logic        short6_r;
  logic [10:0] d2_6_r;
  logic [13:0] base6_r;
  logic        leapc6_r;

  logic [15:0] m7;
  logic [11:0] r7;
  logic        ge7;
  logic [4:0]  n4;
  logic [10:0] d3;
  logic [10:0] d3_7_r;
  logic        leap4_7_r;
  logic [13:0] year4_7_r;

  // single years
  logic [10:0] t1, t2, t3;
  logic [1:0]  y1;
  logic [10:0] yoff;
  logic [8:0]  d4_8_r;
  logic [13:0] year8_r;
  logic        leap8_r;

  // months
  logic [3:0]  mcnt;
  logic [3:0]  month9_r;
  logic [8:0]  d4_9_r;
  logic [13:0] year9_r;
  logic        leap9_r;

  stc_pkg::date_t date_r;

  assign p3  = 45'(days) * 45'(stc_pkg::D400_MUL);
  assign m4  = 22'(n0_3_r) * 22'(stc_pkg::DAYS_400Y);
  assign r4  = days3_r[18:0] - m4[18:0];
  assign ge4 = r4 >= 19'(stc_pkg::DAYS_400Y);

  always_comb begin
    c1 = d1_4_r >= 18'(stc_pkg::DAYS_100Y_FIRST);
    c2 = d1_4_r >= 18'(stc_pkg::DAYS_100Y_FIRST + stc_pkg::DAYS_100Y);
    c3 = d1_4_r >= 18'(stc_pkg::DAYS_100Y_FIRST + 2 * stc_pkg::DAYS_100Y);
    if (c3) begin
      cnum = 2'd3;
      coff = 18'(stc_pkg::DAYS_100Y_FIRST + 2 * stc_pkg::DAYS_100Y);
    end else if (c2) begin
      cnum = 2'd2;
      coff = 18'(stc_pkg::DAYS_100Y_FIRST + stc_pkg::DAYS_100Y);
    end else if (c1) begin
      cnum = 2'd1;
      coff = 18'(stc_pkg::DAYS_100Y_FIRST);
    end else begin
      cnum = 2'd0;
      coff = 18'd0;
    end
  end

  // A non-leap century opens with a 4-year block one day short
  assign e6 = leapc5_r ? d2_5_r : d2_5_r + 16'd1;
  assign p6 = 34'(e6) * 34'(stc_pkg::D1461_MUL);

  assign m7  = 16'(q6_r) * 16'(stc_pkg::DAYS_4Y);
  assign r7  = e6_r[11:0] - m7[11:0];
  assign ge7 = r7 >= 12'(stc_pkg::DAYS_4Y);

  always_comb begin
    if (short6_r) begin
      n4 = 5'd0;
      d3 = d2_6_r;
    end else begin
      n4 = ge7 ? q6_r + 5'd1 : q6_r;
      d3 = 11'(ge7 ? r7 - 12'(stc_pkg::DAYS_4Y) : r7);
    end
  end

  always_comb begin
    t1 = leap4_7_r ? 11'(stc_pkg::DAYS_LEAP_YEAR) : 11'(stc_pkg::DAYS_YEAR);
    t2 = t1 + 11'(stc_pkg::DAYS_YEAR);
    t3 = t2 + 11'(stc_pkg::DAYS_YEAR);
    if (d3_7_r >= t3) begin
      y1   = 2'd3;
      yoff = t3;
    end else if (d3_7_r >= t2) begin
      y1   = 2'd2;
      yoff = t2;
    end else if (d3_7_r >= t1) begin
      y1   = 2'd1;
      yoff = t1;
    end else begin
      y1   = 2'd0;
      yoff = 11'd0;
    end
  end

  always_comb begin
    mcnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (d4_8_r >= stc_pkg::month_start(4'(k), leap8_r)) begin
        mcnt = mcnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[stc_pkg::ST_Q400]) begin
      n0_3_r  <= p3[stc_pkg::D400_SH +: 5];
      days3_r <= days;
    end
    if (en[stc_pkg::ST_R400]) begin
      n400_4_r <= ge4 ? n0_3_r + 5'd1 : n0_3_r;
      d1_4_r   <= 18'(ge4 ? r4 - 19'(stc_pkg::DAYS_400Y) : r4);
    end
    if (en[stc_pkg::ST_CENT]) begin
      d2_5_r   <= 16'(d1_4_r - coff);
      base5_r  <= 14'(14'(n400_4_r) * 14'd400) + 14'(14'(cnum) * 14'd100);
      leapc5_r <= !c1;
    end
    if (en[stc_pkg::ST_Q4]) begin
      e6_r     <= e6;
      q6_r     <= p6[stc_pkg::D1461_SH +: 5];
      short6_r <= !leapc5_r && (d2_5_r < 16'(stc_pkg::DAYS_4Y_SHORT));
      d2_6_r   <= d2_5_r[10:0];
      base6_r  <= base5_r;
      leapc6_r <= leapc5_r;
    end
    if (en[stc_pkg::ST_R4]) begin
      d3_7_r    <= d3;
      leap4_7_r <= leapc6_r || (n4 != 5'd0);
      year4_7_r <= base6_r + 14'({n4, 2'b00});
    end
    if (en[stc_pkg::ST_YEAR]) begin
      d4_8_r  <= 9'(d3_7_r - yoff);
      year8_r <= year4_7_r + 14'(y1);
      leap8_r <= leap4_7_r && (y1 == 2'd0);
    end
    if (en[stc_pkg::ST_MONTH]) begin
      month9_r <= mcnt + 4'd1;
      d4_9_r   <= d4_8_r;
      year9_r  <= year8_r;
      leap9_r  <= leap8_r;
    end
    if (en[stc_pkg::ST_DAY]) begin
      date_r.year  <= year9_r;
      date_r.month <= month9_r;
      date_r.day   <= 5'(d4_9_r - stc_pkg::month_start(month9_r - 4'd1, leap9_r) + 9'd1);
    end
  end

  assign date = date_r;

endmodule

/* rtl/seconds_to_calendar_date_core.sv */
`timescale 1ns / 1ps
// seconds_to_calendar_date_core: converts elapsed seconds to a Gregorian date
// and time of day. Uses stc_pkg, stc_date and stc_tod.
//
// Input channel in_valid/in_ready carries in_elapsed_seconds; the result
// channel out_valid/out_ready carries the date, time and out_of_range flag.
// cfg_we writes cfg_wdata into the epoch mode (0: year 0, 1: 1970-01-01);
// write it only while the pipeline is empty.
// The datapath is an 11-stage pipeline: add and range check, divide by
// 86400 in two stages, then the day count and seconds of day are split in
// parallel (400/100/4/1-year cycles and months; hours/minutes/seconds).
// Throughput: one transaction per cycle while out_ready is high or a stage
// is free.
// Every stage has a valid bit and loads when it is empty or the stage after
// it moves, so bubbles are squeezed out and a stalled receiver only holds
// back as many stages as are full. in_ready drops only when all 11 stages
// hold data and out_ready is low.
// Reset clears all valid bits and the epoch mode.
module seconds_to_calendar_date_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [38:0] in_elapsed_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second,
  output logic        out_out_of_range
);

  logic mode_r;

  stc_pkg::stage_en_t en;
  stc_pkg::stage_en_t v_r;
  stc_pkg::stage_en_t v_nxt;
  stc_pkg::stage_en_t oor_r;
  stc_pkg::stage_en_t oor_nxt;

  logic [39:0] total_nxt;
  logic        oor0;
  logic [39:0] total_r;

  logic [54:0] prod1;
  logic [10:0] x1_r;
  logic [6:0]  lo1_r;
  logic [21:0] q1_r;

  logic [31:0] qm2;
  logic [10:0] r2;
  logic        ge2;
  logic [9:0]  rem2;
  logic [21:0] days_r;
  logic [16:0] sod_r;

  stc_pkg::date_t date;
  stc_pkg::tod_t  tod;

  always_comb begin
    en[stc_pkg::LAST] = !v_r[stc_pkg::LAST] || out_ready;
    for (int k = stc_pkg::LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[stc_pkg::ST_TOTAL];

  assign total_nxt = 40'(in_elapsed_seconds) + (mode_r ? stc_pkg::UNIX_OFFSET : 40'd0);
  assign oor0      = total_nxt >= stc_pkg::LIMIT_SECS;

  always_comb begin
    v_nxt[stc_pkg::ST_TOTAL]   = en[stc_pkg::ST_TOTAL] ? in_valid : v_r[stc_pkg::ST_TOTAL];
    oor_nxt[stc_pkg::ST_TOTAL] = en[stc_pkg::ST_TOTAL] ? oor0 : oor_r[stc_pkg::ST_TOTAL];
    for (int k = 1; k < stc_pkg::NSTAGE; k++) begin
      v_nxt[k]   = en[k] ? v_r[k-1] : v_r[k];
      oor_nxt[k] = en[k] ? oor_r[k-1] : oor_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      mode_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  // seconds / 86400 as (seconds >> 7) / 675
  assign prod1 = 55'(total_r[38:stc_pkg::DAY_LO_W]) * 55'(stc_pkg::D675_MUL);
  assign qm2   = 32'(q1_r) * 32'(stc_pkg::D675);
  assign r2    = x1_r - qm2[10:0];
  assign ge2   = r2 >= 11'(stc_pkg::D675);
  assign rem2  = 10'(ge2 ? r2 - 11'(stc_pkg::D675) : r2);

  always_ff @(posedge clk) begin
    oor_r <= oor_nxt;
    if (en[stc_pkg::ST_TOTAL]) begin
      total_r <= total_nxt;
    end
    if (en[stc_pkg::ST_Q675]) begin
      x1_r  <= total_r[stc_pkg::DAY_LO_W +: 11];
      lo1_r <= total_r[stc_pkg::DAY_LO_W-1:0];
      q1_r  <= prod1[stc_pkg::D675_SH +: 22];
    end
    if (en[stc_pkg::ST_SPLIT]) begin
      days_r <= ge2 ? q1_r + 22'd1 : q1_r;
      sod_r  <= {rem2, lo1_r};
    end
  end

  stc_date u_date (
    .clk  (clk),
    .en   (en),
    .days (days_r),
    .date (date)
  );

  stc_tod u_tod (
    .clk (clk),
    .en  (en),
    .sod (sod_r),
    .tod (tod)
  );

  assign out_valid        = v_r[stc_pkg::LAST];
  assign out_out_of_range = oor_r[stc_pkg::LAST];
  assign out_cal_year     = out_out_of_range ? 14'd0 : date.year;
  assign out_cal_month    = out_out_of_range ? 4'd0  : date.month;
  assign out_cal_day      = out_out_of_range ? 5'd0  : date.day;
  assign out_cal_hour     = out_out_of_range ? 5'd0  : tod.hour;
  assign out_cal_minute   = out_out_of_range ? 6'd0  : tod.minute;
  assign out_cal_second   = out_out_of_range ? 6'd0  : tod.second;

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_cal_month >= 4'd1 && out_cal_month <= 4'd12 &&
      out_cal_day >= 5'd1 && out_cal_hour <= 5'd23 &&
      out_cal_minute <= 6'd59 && out_cal_second <= 6'd59)
    else $error("calendar field out of range");

  a_feb_days: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range && out_cal_month == 4'd2 |-> out_cal_day <= 5'd29)
    else $error("february day past 29");

  a_short_months: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range &&
    (out_cal_month == 4'd4 || out_cal_month == 4'd6 ||
     out_cal_month == 4'd9 || out_cal_month == 4'd11) |-> out_cal_day <= 5'd30)
    else $error("30-day month past 30");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &v_r)
    else $error("input blocked with an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[stc_pkg::ST_TOTAL])
    else $error("accepted transaction lost at first stage");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for seconds_to_calendar_date_core. It predicts each
// date and time from the elapsed seconds and the epoch mode. Depends on stc_pkg and the core.
module testbench;

  localparam longint unsigned SECS_PER_DAY    = 64'd86400;
  localparam longint unsigned EPOCH_1970_SECS = 64'd62167219200;
  localparam longint unsigned SECS_LIMIT      = 64'd315569520000;
  localparam longint unsigned DAYS_PER_400Y   = 64'd146097;
  localparam longint unsigned DAYS_FIRST_100Y = 64'd36525;
  localparam longint unsigned DAYS_PER_100Y   = 64'd36524;
  localparam longint unsigned DAYS_PER_4Y     = 64'd1461;
  localparam longint unsigned DAYS_SHORT_4Y   = 64'd1460;
  localparam longint unsigned DAYS_LEAP       = 64'd366;
  localparam longint unsigned DAYS_COMMON     = 64'd365;
  localparam bit MODE_YEAR0 = 1'b0;
  localparam bit MODE_UNIX  = 1'b1;

  typedef struct packed {
    stc_pkg::date_t date;
    stc_pkg::tod_t  tod;
    logic           out_of_range;
  } cal_stamp_t;

  class calendar_scoreboard;
    cal_stamp_t expected_q[$];
    bit unix_epoch;
    int mismatches;
    int results_seen;
    int oor_seen;

    function bit leap_year(longint unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function cal_stamp_t predict(logic [38:0] secs);
      cal_stamp_t res;
      longint unsigned total, days, sod, year, month, mlen;
      int unsigned month_days [12];
      month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      res = '0;
      total = 64'(secs);
      if (unix_epoch) total += EPOCH_1970_SECS;
      if (total >= SECS_LIMIT) begin
        res.out_of_range = 1'b1;
        return res;
      end
      sod  = total % SECS_PER_DAY;
      days = total / SECS_PER_DAY;
      year = 400 * (days / DAYS_PER_400Y);
      days = days % DAYS_PER_400Y;
      if (days >= DAYS_FIRST_100Y) begin
        year += 100;
        days -= DAYS_FIRST_100Y;
        year += 100 * (days / DAYS_PER_100Y);
        days = days % DAYS_PER_100Y;
      end
      if (leap_year(year)) begin
        year += 4 * (days / DAYS_PER_4Y);
        days = days % DAYS_PER_4Y;
      end else if (days >= DAYS_SHORT_4Y) begin
        year += 4;
        days -= DAYS_SHORT_4Y;
        year += 4 * (days / DAYS_PER_4Y);
        days = days % DAYS_PER_4Y;
      end
      if (leap_year(year)) begin
        if (days >= DAYS_LEAP) begin
          year += 1;
          days -= DAYS_LEAP;
          year += days / DAYS_COMMON;
          days = days % DAYS_COMMON;
        end
      end else begin
        year += days / DAYS_COMMON;
        days = days % DAYS_COMMON;
      end
      month = 1;
      while (month < 12) begin
        mlen = month_days[month - 1];
        if (month == 2 && leap_year(year)) mlen = 29;
        if (days < mlen) break;
        days -= mlen;
        month++;
      end
      res.date.year   = 14'(year);
      res.date.month  = 4'(month);
      res.date.day    = 5'(days + 1);
      res.tod.hour    = 5'(sod / 3600);
      res.tod.minute  = 6'((sod / 60) % 60);
      res.tod.second  = 6'(sod % 60);
      return res;
    endfunction

    function void note_input(logic [38:0] secs);
      expected_q.push_back(predict(secs));
    endfunction

    function void field_check(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_result(cal_stamp_t got);
      cal_stamp_t exp;
      results_seen++;
      if (got.out_of_range) oor_seen++;
      if (expected_q.size() == 0) begin
        $error("result transaction with no conversion pending");
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      field_check("cal_year", exp.date.year, got.date.year);
      field_check("cal_month", exp.date.month, got.date.month);
      field_check("cal_day", exp.date.day, got.date.day);
      field_check("cal_hour", exp.tod.hour, got.tod.hour);
      field_check("cal_minute", exp.tod.minute, got.tod.minute);
      field_check("cal_second", exp.tod.second, got.tod.second);
      field_check("out_of_range", exp.out_of_range, got.out_of_range);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [38:0] in_elapsed_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] out_cal_year;
  logic [3:0]  out_cal_month;
  logic [4:0]  out_cal_day;
  logic [4:0]  out_cal_hour;
  logic [5:0]  out_cal_minute;
  logic [5:0]  out_cal_second;
  logic        out_out_of_range;

  calendar_scoreboard sb;
  int rx_hold_cycles = 0;
  int backpressure_cycles = 0;
  int mode_writes = 0;
  int day_marks [18] = '{0, 31, 59, 60, 365, 366, 1460, 1461, 1520, 36524, 36525, 36583,
                         36584, 73048, 73049, 109573, 146037, 146096};

  seconds_to_calendar_date_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_elapsed_seconds (in_elapsed_seconds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cal_year       (out_cal_year),
    .out_cal_month      (out_cal_month),
    .out_cal_day        (out_cal_day),
    .out_cal_hour       (out_cal_hour),
    .out_cal_minute     (out_cal_minute),
    .out_cal_second     (out_cal_second),
    .out_out_of_range   (out_out_of_range)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL seconds_to_calendar_date_core");
    $finish;
  end

  task automatic send_item(input logic [38:0] secs, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_seconds <= secs;
    do begin
      @(posedge clk);
      if (!in_ready) backpressure_cycles++;
    end while (!in_ready);
    sb.note_input(secs);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_epoch_mode(input bit mode);
    drain();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.unix_epoch = mode;
    mode_writes++;
  endtask

  function automatic logic [38:0] random_seconds(bit unix_mode);
    longint unsigned r, total, day;
    int kind, off;
    r = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 6) return r[38:0];
    if (kind < 60) begin
      total = r % SECS_LIMIT;
    end else begin
      off = day_marks[$urandom_range(0, 17)] + $urandom_range(0, 2) - 1;
      if (off < 0) off = 0;
      day = longint'($urandom_range(0, 24)) * DAYS_PER_400Y + longint'(off);
      case ($urandom_range(0, 2))
        0: total = day * SECS_PER_DAY;
        1: total = day * SECS_PER_DAY + SECS_PER_DAY - 1;
        default: total = day * SECS_PER_DAY + $urandom_range(0, 86399);
      endcase
    end
    if (unix_mode && total >= EPOCH_1970_SECS) total -= EPOCH_1970_SECS;
    return total[38:0];
  endfunction

  task automatic run_random(input int count);
    bit burst;
    int gap;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 5);
      send_item(random_seconds(sb.unix_epoch), gap);
    end
  endtask

  // receiver: random stalls, burst stretches, and one long hold on request
  initial begin
    int stall, count;
    bit burst;
    cal_stamp_t got;
    count = 0;
    burst = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.date.year    = out_cal_year;
      got.date.month   = out_cal_month;
      got.date.day     = out_cal_day;
      got.tod.hour     = out_cal_hour;
      got.tod.minute   = out_cal_minute;
      got.tod.second   = out_cal_second;
      got.out_of_range = out_out_of_range;
      sb.check_result(got);
      count++;
      if (count % 64 == 0) burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counted from year 0
    send_item(39'd0, 0);
    send_item(39'd59, 1);
    send_item(39'd60, 0);
    send_item(39'd3599, 2);
    send_item(39'd3600, 0);
    send_item(39'd86399, 0);
    send_item(39'd86400, 3);
    send_item(39'd5097600, 0);
    send_item(39'd31622399, 0);
    send_item(39'd31622400, 1);
    send_item(39'd131328000, 0);
    send_item(39'd3155760000, 0);
    send_item(39'd3160857600, 0);
    send_item(39'd12622780800, 5);
    send_item(39'd12627878400, 0);
    send_item(39'd315569519999, 0);
    send_item(39'd315569520000, 0);
    send_item(39'h7F_FFFF_FFFF, 0);

    // counted from 1970
    set_epoch_mode(MODE_UNIX);
    send_item(39'd0, 0);
    send_item(39'd951782400, 0);
    send_item(39'd1234567890, 2);
    send_item(39'd253402300799, 0);
    send_item(39'd253402300800, 0);
    send_item(39'h7F_FFFF_FFFF, 0);

    set_epoch_mode(MODE_YEAR0);
    run_random(300);
    drain();

    // hold the receiver while the sender keeps offering at full rate
    rx_hold_cycles = 80;
    for (int i = 0; i < 40; i++) send_item(random_seconds(sb.unix_epoch), 0);

    set_epoch_mode(MODE_UNIX);
    run_random(300);
    set_epoch_mode(MODE_YEAR0);
    run_random(250);
    set_epoch_mode(MODE_UNIX);
    run_random(280);

    drain();
    repeat (30) @(posedge clk);
    $display("Checked %0d conversions (%0d past year 9999) across %0d epoch mode writes;",
             sb.results_seen, sb.oor_seen, mode_writes);
    $display("input was held off for %0d cycles in total.", backpressure_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS seconds_to_calendar_date_core");
    end else begin
      $display("FAIL seconds_to_calendar_date_core");
    end
    $finish;
  end

endmodule
